### hdl/aes_pkg.sv
// Shared types, constants and byte functions for the AES block cipher.
package aes_pkg;

  localparam int ScheduleWordsDefault = 60;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2,
    KEY_RSV = 2'd3
  } key_size_t;

  typedef enum logic [2:0] {
    REG_KEY_SIZE = 3'd0,
    REG_KEY_0    = 3'd1,
    REG_KEY_1    = 3'd2,
    REG_KEY_2    = 3'd3,
    REG_KEY_3    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP_LOAD,
    ST_EXP_RD,
    ST_EXP_WAIT,
    ST_EXP_WR,
    ST_RK_RD,
    ST_RK_WAIT,
    ST_RK_LATCH,
    ST_ROUND,
    ST_DONE
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

### hdl/aes_ram.sv
// Generic single-port-write, registered-read RAM.
module aes_ram #(
  parameter int Width = 32,
  parameter int Depth = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/aes_round.sv
// One AES round unit, forward or inverse, shared by every round.
module aes_round (
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         inverse,
  input  logic         first,
  input  logic         last,
  output logic [127:0] state_out
);
  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] u [16];
  logic [7:0] k [16];
  logic [7:0] m [16];
  logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3, e0, e1, e2, e3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127-8*i -: 8];
      k[i] = round_key[127-8*i -: 8];
    end
    // shift rows and substitute bytes
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) begin
          t[((c + r) % 4) * 4 + r] = aes_pkg::INV_SBOX[s[c*4 + r]];
        end else begin
          t[c*4 + r] = aes_pkg::SBOX[s[((c + r) % 4) * 4 + r]];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      u[i] = inverse ? (t[i] ^ k[i]) : t[i];
    end
    for (int c = 0; c < 4; c++) begin
      a0 = u[c*4]; a1 = u[c*4+1]; a2 = u[c*4+2]; a3 = u[c*4+3];
      d0 = aes_pkg::xt(a0); d1 = aes_pkg::xt(a1);
      d2 = aes_pkg::xt(a2); d3 = aes_pkg::xt(a3);
      if (inverse) begin
        // fold inverse matrix into forward one plus a premix
        e0 = aes_pkg::xt(aes_pkg::xt(a0 ^ a2));
        e1 = aes_pkg::xt(aes_pkg::xt(a1 ^ a3));
        a0 = a0 ^ e0; a1 = a1 ^ e1; a2 = a2 ^ e0; a3 = a3 ^ e1;
        d0 = aes_pkg::xt(a0); d1 = aes_pkg::xt(a1);
        d2 = aes_pkg::xt(a2); d3 = aes_pkg::xt(a3);
      end else begin
        e0 = 8'h00;
        e1 = 8'h00;
      end
      e2 = a0 ^ a1 ^ a2 ^ a3;
      e3 = e2;
      m[c*4]   = a0 ^ e2 ^ d0 ^ d1;
      m[c*4+1] = a1 ^ e3 ^ d1 ^ d2;
      m[c*4+2] = a2 ^ e2 ^ d2 ^ d3;
      m[c*4+3] = a3 ^ e3 ^ d3 ^ d0;
    end
    for (int i = 0; i < 16; i++) begin
      if (first) begin
        state_out[127-8*i -: 8] = s[i] ^ k[i];
      end else if (last) begin
        state_out[127-8*i -: 8] = inverse ? u[i] : (t[i] ^ k[i]);
      end else begin
        state_out[127-8*i -: 8] = inverse ? m[i] : (m[i] ^ k[i]);
      end
    end
  end
endmodule

### hdl/aes_block_cipher_top.sv
// AES block cipher top level: config registers, key expansion and round sequencer.
// A block taken with a stale schedule first expands it, loading the key words and then
// computing the rest, writing each schedule word (44, 52 or 60) to the RAM. Each of the
// Nr+1 round keys is then read column by column through the registered RAM port (read,
// wait, latch per column) before the round is applied, for Nr = 10, 12 or 14.
// One block at a time; in_ready returns the cycle after the result word is taken, unless cfg_valid is high.
// Reset (synchronous, rst high) clears the key registers and marks the schedule stale.
module aes_block_cipher_top #(
  parameter int ScheduleWords = aes_pkg::ScheduleWordsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  aes_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aes_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  aes_pkg::cfg_word_t  cfg_data
);
  localparam int AW = $clog2(ScheduleWords);

  aes_pkg::state_t state, state_next;
  logic [1:0]   key_size;
  logic [63:0]  key_part [4];
  logic         schedule_ready;
  logic [3:0]   rounds;
  logic [3:0]   nk;
  logic [2:0]   last_w;
  logic [5:0]   total;
  logic [5:0]   widx;
  logic [2:0]   kcnt;
  logic [7:0]   rcon;
  logic [31:0]  win [8];
  logic [31:0]  key_word;
  logic [31:0]  t_word, new_word;
  logic         we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]  wdata, rdata;
  logic [1:0]   col;
  logic [3:0]   rnd;
  logic [127:0] rkey, blk, round_out;
  logic         inv;
  logic [1:0]   sel_sz;

  assign cfg_ready = (state == aes_pkg::ST_IDLE);
  assign in_ready  = (state == aes_pkg::ST_IDLE) && !cfg_valid;
  assign out_valid = (state == aes_pkg::ST_DONE);
  assign out_data  = {blk[127:64], blk[63:0]};

  // size actually used: reserved acts as 256, shrink to fit the store
  always_comb begin
    sel_sz = (key_size == aes_pkg::KEY_RSV) ? aes_pkg::KEY_256 : key_size;
    if (sel_sz == aes_pkg::KEY_256 && ScheduleWords < 60) sel_sz = aes_pkg::KEY_192;
    if (sel_sz == aes_pkg::KEY_192 && ScheduleWords < 52) sel_sz = aes_pkg::KEY_128;
  end
  assign nk     = 4'd4 + {1'b0, sel_sz, 1'b0};
  assign last_w = 3'(nk - 4'd1);
  assign total  = 6'd44 + {1'b0, sel_sz, 3'b000};

  assign key_word = widx[0] ? key_part[widx[2:1]][31:0] : key_part[widx[2:1]][63:32];

  aes_ram #(.Width(32), .Depth(ScheduleWords)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  aes_round u_round (
    .state_in(blk), .round_key(rkey), .inverse(inv),
    .first(rnd == 4'd0), .last(rnd == rounds), .state_out(round_out)
  );

  // expansion word: win[0] is w[i-nk], win[nk-1] is w[i-1]
  always_comb begin
    t_word = win[last_w];
    if (kcnt == 3'd0) begin
      t_word = aes_pkg::sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon, 24'h0};
    end else if (nk > 4'd6 && kcnt == 3'd4) begin
      t_word = aes_pkg::sub_word(t_word);
    end
    new_word = win[0] ^ t_word;
  end

  always_comb begin
    we    = 1'b0;
    waddr = widx[AW-1:0];
    wdata = new_word;
    if (state == aes_pkg::ST_EXP_LOAD) begin
      we    = 1'b1;
      wdata = key_word;
    end else if (state == aes_pkg::ST_EXP_WR) begin
      we = 1'b1;
    end
    raddr = inv ? AW'((rounds - rnd) * 4 + col) : AW'(rnd * 4 + col);
  end

  always_comb begin
    state_next = state;
    case (state)
      aes_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = schedule_ready ? aes_pkg::ST_RK_RD : aes_pkg::ST_EXP_LOAD;
        end
      end
      aes_pkg::ST_EXP_LOAD: begin
        if (widx == 6'(nk) - 6'd1) state_next = aes_pkg::ST_EXP_WR;
      end
      aes_pkg::ST_EXP_RD:   state_next = aes_pkg::ST_EXP_WAIT;
      aes_pkg::ST_EXP_WAIT: state_next = aes_pkg::ST_EXP_WR;
      aes_pkg::ST_EXP_WR: begin
        if (widx == total - 6'd1) state_next = aes_pkg::ST_RK_RD;
      end
      aes_pkg::ST_RK_RD:    state_next = aes_pkg::ST_RK_WAIT;
      aes_pkg::ST_RK_WAIT:  state_next = aes_pkg::ST_RK_LATCH;
      aes_pkg::ST_RK_LATCH: state_next = (col == 2'd3) ? aes_pkg::ST_ROUND : aes_pkg::ST_RK_RD;
      aes_pkg::ST_ROUND:    state_next = (rnd == rounds) ? aes_pkg::ST_DONE : aes_pkg::ST_RK_RD;
      aes_pkg::ST_DONE: begin
        if (out_ready) state_next = aes_pkg::ST_IDLE;
      end
      default: state_next = aes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= aes_pkg::ST_IDLE;
      key_size       <= 2'd0;
      schedule_ready <= 1'b0;
      for (int i = 0; i < 4; i++) key_part[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          aes_pkg::REG_KEY_SIZE: begin
            key_size <= cfg_data.data[1:0]; schedule_ready <= 1'b0;
          end
          aes_pkg::REG_KEY_0: begin key_part[0] <= cfg_data.data; schedule_ready <= 1'b0; end
          aes_pkg::REG_KEY_1: begin key_part[1] <= cfg_data.data; schedule_ready <= 1'b0; end
          aes_pkg::REG_KEY_2: begin key_part[2] <= cfg_data.data; schedule_ready <= 1'b0; end
          aes_pkg::REG_KEY_3: begin key_part[3] <= cfg_data.data; schedule_ready <= 1'b0; end
          default: ;
        endcase
      end
      if (state == aes_pkg::ST_EXP_WR && widx == total - 6'd1) schedule_ready <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      aes_pkg::ST_IDLE: begin
        inv    <= in_data.op;
        blk    <= {in_data.block_high, in_data.block_low};
        col    <= 2'd0;
        rnd    <= 4'd0;
        widx   <= 6'd0;
        kcnt   <= 3'd0;
        rcon   <= 8'h01;
        if (schedule_ready) rounds <= rounds;
        else rounds <= 4'd10 + {1'b0, sel_sz, 1'b0};
      end
      aes_pkg::ST_EXP_LOAD: begin
        win[widx[2:0]] <= key_word;
        widx <= widx + 6'd1;
        kcnt <= 3'd0;
      end
      aes_pkg::ST_EXP_WR: begin
        // advance the window, newest word lands at the top
        for (int i = 0; i < 7; i++) win[i] <= (3'(i) == last_w) ? new_word : win[i+1];
        if (last_w == 3'd7) win[7] <= new_word;
        widx <= widx + 6'd1;
        kcnt <= (kcnt == last_w) ? 3'd0 : kcnt + 3'd1;
        if (kcnt == 3'd0) rcon <= aes_pkg::xt(rcon);
      end
      aes_pkg::ST_RK_LATCH: begin
        rkey[127 - 32*col -: 32] <= rdata;
        col <= col + 2'd1;
      end
      aes_pkg::ST_ROUND: begin
        blk <= round_out;
        rnd <= rnd + 4'd1;
      end
      default: ;
    endcase
  end
endmodule
